>>> rtl/rgbfb_pkg.sv
// Shared constants and types for the RGB to framebuffer pixel converter.
package rgbfb_pkg;

   localparam int PALETTE_DEPTH_DEFAULT = 256;
   localparam int COLOR_W               = 24;
   localparam int PIXEL_W               = 32;
   localparam int COUNT_W               = 9;
   localparam int DIST_W                = 18;
   localparam logic [DIST_W-1:0] DIST_START = DIST_W'(3 * 256 * 256);

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_MODE        = 3'd0,
      REG_RED_POS     = 3'd1,
      REG_RED_SIZE    = 3'd2,
      REG_GREEN_POS   = 3'd3,
      REG_GREEN_SIZE  = 3'd4,
      REG_BLUE_POS    = 3'd5,
      REG_BLUE_SIZE   = 3'd6,
      REG_COLOR_COUNT = 3'd7
   } reg_index_type;

   // Status that the palette search reports back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } search_stat_type;

endpackage

>>> rtl/rgb_to_framebuffer_pixel.sv
// Top level: converts RGB colors to framebuffer pixels, direct or by palette.
//
//   Channel   Direction  Handshake            Contents
//   req_      in         req_valid/req_ready  kind, color, entry_index, entry_color
//   rsp_      out        rsp_valid/rsp_ready  pixel
//   csr_      in         csr_wr_en            csr_index, csr_wr_data
//
// A palette write request is taken from IDLE and produces no response.
// A direct-mode conversion passes through PACK and REPLY before rsp_valid
// rises. A palette-mode conversion waits in SEARCH while the distance unit
// reads one palette entry per cycle, up to the saturated entry count,
// through a three-stage read, square and compare pipeline, then goes
// through REPLY. The next request is taken once the sequencer is idle.
// Reset is synchronous and active high; the palette memory is not cleared.
// The block takes one conversion at a time; a response that is not taken
// holds the next result back, so req_ready stays low until it drains.
module rgb_to_framebuffer_pixel #(
   parameter int PALETTE_DEPTH = rgbfb_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [rgbfb_pkg::COLOR_W-1:0] req_color,
   input  logic [7:0]                    req_entry_index,
   input  logic [rgbfb_pkg::COLOR_W-1:0] req_entry_color,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rgbfb_pkg::PIXEL_W-1:0] rsp_pixel,
   input  logic                          csr_wr_en,
   input  logic [2:0]                    csr_index,
   input  logic [rgbfb_pkg::COUNT_W-1:0] csr_wr_data
);
   import rgbfb_pkg::*;

   localparam int IDX_W = $clog2(PALETTE_DEPTH);
   localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PACK,
      ST_SEARCH,
      ST_REPLY
   } state_type;

   state_type             state_ff;
   logic                  mode_ff;
   logic [4:0]            red_pos_ff;
   logic [3:0]            red_size_ff;
   logic [4:0]            green_pos_ff;
   logic [3:0]            green_size_ff;
   logic [4:0]            blue_pos_ff;
   logic [3:0]            blue_size_ff;
   logic [COUNT_W-1:0]    color_count_ff;

   logic [COLOR_W-1:0]    color_ff;
   logic [PIXEL_W-1:0]    result_ff;
   logic                  rsp_valid_ff;
   logic [PIXEL_W-1:0]    rsp_pixel_ff;

   logic                  req_accept;
   logic                  rsp_load;
   logic                  wr_en;
   logic                  search_start;
   logic [CNT_W-1:0]      search_count;
   logic [PIXEL_W-1:0]    packed_pixel;
   search_stat_type       search_stat;
   logic [IDX_W-1:0]      best_idx;

   // Keeps the low size bits of a component (all eight when size exceeds
   // eight) and moves them to pos; bits pushed past bit 31 fall off.
   function automatic logic [PIXEL_W-1:0] place_field(input logic [7:0] comp,
                                                      input logic [4:0] pos,
                                                      input logic [3:0] size);
      logic [3:0] keep_w;
      logic [7:0] mask;
      keep_w = (size > 4'd8) ? 4'd8 : size;
      mask   = 8'((9'd1 << keep_w) - 9'd1);
      return PIXEL_W'(comp & mask) << pos;
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         red_pos_ff     <= 5'd16;
         red_size_ff    <= 4'd8;
         green_pos_ff   <= 5'd8;
         green_size_ff  <= 4'd8;
         blue_pos_ff    <= 5'd0;
         blue_size_ff   <= 4'd8;
         color_count_ff <= COUNT_W'(16);
      end else if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_MODE:        mode_ff        <= csr_wr_data[0];
            REG_RED_POS:     red_pos_ff     <= csr_wr_data[4:0];
            REG_RED_SIZE:    red_size_ff    <= csr_wr_data[3:0];
            REG_GREEN_POS:   green_pos_ff   <= csr_wr_data[4:0];
            REG_GREEN_SIZE:  green_size_ff  <= csr_wr_data[3:0];
            REG_BLUE_POS:    blue_pos_ff    <= csr_wr_data[4:0];
            REG_BLUE_SIZE:   blue_size_ff   <= csr_wr_data[3:0];
            REG_COLOR_COUNT: color_count_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;

   // A finished result moves into the response register when that register
   // is empty or is being drained in the same cycle.
   assign rsp_load = (state_ff == ST_REPLY) && (!rsp_valid_ff || rsp_ready);

   // Writes to entries past the palette depth are dropped.
   assign wr_en = req_accept && req_kind &&
                  ({1'b0, req_entry_index} < 9'(PALETTE_DEPTH));

   assign search_start = req_accept && !req_kind && mode_ff;

   // The entry count saturates at the palette depth.
   assign search_count = (color_count_ff > COUNT_W'(PALETTE_DEPTH)) ?
                         CNT_W'(PALETTE_DEPTH) : CNT_W'(color_count_ff);

   assign packed_pixel = place_field(color_ff[23:16], red_pos_ff,   red_size_ff)
                       | place_field(color_ff[15:8],  green_pos_ff, green_size_ff)
                       | place_field(color_ff[7:0],   blue_pos_ff,  blue_size_ff);

   rgbfb_search #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .IDX_W         (IDX_W),
      .CNT_W         (CNT_W)
   ) u_search (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (req_entry_index[IDX_W-1:0]),
      .wr_data  (req_entry_color),
      .start    (search_start),
      .count    (search_count),
      .color    (req_color),
      .stat     (search_stat),
      .best_idx (best_idx)
   );

   // Sequencer and response register. A finished result waits in REPLY
   // until the response register is free or being drained.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && !req_kind) begin
                  color_ff <= req_color;
                  state_ff <= mode_ff ? ST_SEARCH : ST_PACK;
               end
            end
            ST_PACK: begin
               result_ff <= packed_pixel;
               state_ff  <= ST_REPLY;
            end
            ST_SEARCH: begin
               if (search_stat.done) begin
                  result_ff <= PIXEL_W'(best_idx);
                  state_ff  <= ST_REPLY;
               end
            end
            ST_REPLY: begin
               if (rsp_load) begin
                  rsp_pixel_ff <= result_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;

   a_write_no_reply: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind) |=> (state_ff == ST_IDLE))
      else $error("palette write left the idle state");

   a_search_in_state: assert property (@(posedge clock) disable iff (reset)
      search_stat.busy |-> (state_ff == ST_SEARCH))
      else $error("search unit busy outside the search state");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel)))
      else $error("response dropped or changed while waiting");

endmodule

>>> rtl/rgbfb_search.sv
// Palette memory and the pipelined nearest-color distance unit.
module rgbfb_search #(
   parameter int PALETTE_DEPTH = rgbfb_pkg::PALETTE_DEPTH_DEFAULT,
   parameter int IDX_W         = $clog2(PALETTE_DEPTH),
   parameter int CNT_W         = $clog2(PALETTE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_addr,
   input  logic [rgbfb_pkg::COLOR_W-1:0] wr_data,
   input  logic                          start,
   input  logic [CNT_W-1:0]              count,
   input  logic [rgbfb_pkg::COLOR_W-1:0] color,
   output rgbfb_pkg::search_stat_type    stat,
   output logic [IDX_W-1:0]              best_idx
);
   import rgbfb_pkg::*;

   logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];

   logic               busy_ff;
   logic               issue_ff;
   logic [CNT_W-1:0]   addr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [COLOR_W-1:0] color_ff;

   logic               s1_valid_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic [COLOR_W-1:0] rd_data_ff;

   logic               s2_valid_ff;
   logic [IDX_W-1:0]   s2_idx_ff;
   logic [15:0]        sq_r_ff;
   logic [15:0]        sq_g_ff;
   logic [15:0]        sq_b_ff;

   logic [DIST_W-1:0]  best_dist_ff;
   logic [IDX_W-1:0]   best_idx_ff;

   logic [CNT_W-1:0]   addr_in;
   logic [7:0]         diff_r;
   logic [7:0]         diff_g;
   logic [7:0]         diff_b;
   logic [DIST_W-1:0]  entry_dist;
   logic               done;

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= palette_mem[addr_ff[IDX_W-1:0]];
   end

   assign addr_in = addr_ff + CNT_W'(1);
   assign done    = busy_ff && !issue_ff && !s1_valid_ff && !s2_valid_ff;

   // Read address sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         issue_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue_ff;
         s2_valid_ff <= s1_valid_ff;
         if (start) begin
            busy_ff  <= 1'b1;
            issue_ff <= (count != '0);
            addr_ff  <= '0;
            count_ff <= count;
            color_ff <= color;
         end else begin
            if (done) begin
               busy_ff <= 1'b0;
            end
            if (issue_ff) begin
               addr_ff <= addr_in;
               if (addr_in == count_ff) begin
                  issue_ff <= 1'b0;
               end
            end
         end
      end
   end

   assign diff_r = abs_diff(color_ff[23:16], rd_data_ff[23:16]);
   assign diff_g = abs_diff(color_ff[15:8],  rd_data_ff[15:8]);
   assign diff_b = abs_diff(color_ff[7:0],   rd_data_ff[7:0]);

   // Square stage and compare stage.
   always_ff @(posedge clock) begin
      s1_idx_ff <= addr_ff[IDX_W-1:0];
      s2_idx_ff <= s1_idx_ff;
      sq_r_ff   <= diff_r * diff_r;
      sq_g_ff   <= diff_g * diff_g;
      sq_b_ff   <= diff_b * diff_b;
   end

   assign entry_dist = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

   always_ff @(posedge clock) begin
      if (start) begin
         best_dist_ff <= DIST_START;
         best_idx_ff  <= '0;
      end else if (s2_valid_ff && (entry_dist < best_dist_ff)) begin
         best_dist_ff <= entry_dist;
         best_idx_ff  <= s2_idx_ff;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done;
   assign best_idx  = best_idx_ff;

   a_dist_monotonic: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && $past(busy_ff)) |-> (best_dist_ff <= $past(best_dist_ff)))
      else $error("best distance grew during a search");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> (addr_ff < count_ff))
      else $error("palette read beyond the searched count");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (count_ff != '0)) |-> (CNT_W'(best_idx_ff) < count_ff))
      else $error("best index outside the searched entries");

endmodule
